FILE: rtl/core/mnes_pkg.sv
// Package for the MIDI note event serializer: control word, microcode ROM and constants.
package mnes_pkg;

    localparam int unsigned DUR_W    = 16;
    localparam int unsigned NOTE_W   = 7;
    localparam int unsigned SCALE_W  = 28;
    localparam int unsigned CHAN_W   = 4;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned TICKS_W  = 28;
    localparam int unsigned PC_W     = 4;

    localparam logic [SCALE_W-1:0] TICK_SCALE_RESET = 28'd65536;
    localparam logic [7:0]         NOTE_ON_STATUS   = 8'h90;

    // Configuration register indexes
    localparam logic CFG_TICK_SCALE   = 1'b0;
    localparam logic CFG_MIDI_CHANNEL = 1'b1;

    // Byte sources
    localparam logic [2:0] SRC_ZERO   = 3'd0;
    localparam logic [2:0] SRC_STATUS = 3'd1;
    localparam logic [2:0] SRC_NOTE   = 3'd2;
    localparam logic [2:0] SRC_VEL    = 3'd3;
    localparam logic [2:0] SRC_G3     = 3'd4;
    localparam logic [2:0] SRC_G2     = 3'd5;
    localparam logic [2:0] SRC_G1     = 3'd6;
    localparam logic [2:0] SRC_G0     = 3'd7;

    // Jump kinds
    localparam logic [1:0] JMP_NEXT = 2'd0;
    localparam logic [1:0] JMP_VLQ  = 2'd1;
    localparam logic [1:0] JMP_HOME = 2'd2;

    // Program steps
    localparam logic [PC_W-1:0] STEP_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] STEP_MUL     = 4'd1;
    localparam logic [PC_W-1:0] STEP_DELTA   = 4'd2;
    localparam logic [PC_W-1:0] STEP_ON_ST   = 4'd3;
    localparam logic [PC_W-1:0] STEP_ON_NOTE = 4'd4;
    localparam logic [PC_W-1:0] STEP_ON_VEL  = 4'd5;
    localparam logic [PC_W-1:0] STEP_G3      = 4'd6;
    localparam logic [PC_W-1:0] STEP_G2      = 4'd7;
    localparam logic [PC_W-1:0] STEP_G1      = 4'd8;
    localparam logic [PC_W-1:0] STEP_G0      = 4'd9;
    localparam logic [PC_W-1:0] STEP_OFF_ST  = 4'd10;
    localparam logic [PC_W-1:0] STEP_OFF_NOTE= 4'd11;
    localparam logic [PC_W-1:0] STEP_OFF_VEL = 4'd12;

    typedef struct packed {
        logic       wait_in;  // hold until an input word arrives
        logic       load_mul; // latch the scaled duration
        logic       emit;     // push one output byte
        logic [2:0] src;
        logic       cont;     // set bit 7 on a quantity byte
        logic       last;
        logic [1:0] jmp;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{wait_in: 1'b0, load_mul: 1'b0, emit: 1'b0, src: SRC_ZERO,
              cont: 1'b0, last: 1'b0, jmp: JMP_HOME};
        unique case (pc)
            STEP_IDLE:     begin w.wait_in = 1'b1; w.jmp = JMP_NEXT; end
            STEP_MUL:      begin w.load_mul = 1'b1; w.jmp = JMP_NEXT; end
            STEP_DELTA:    begin w.emit = 1'b1; w.src = SRC_ZERO;   w.jmp = JMP_NEXT; end
            STEP_ON_ST:    begin w.emit = 1'b1; w.src = SRC_STATUS; w.jmp = JMP_NEXT; end
            STEP_ON_NOTE:  begin w.emit = 1'b1; w.src = SRC_NOTE;   w.jmp = JMP_NEXT; end
            STEP_ON_VEL:   begin w.emit = 1'b1; w.src = SRC_VEL;    w.jmp = JMP_VLQ;  end
            STEP_G3:       begin w.emit = 1'b1; w.src = SRC_G3; w.cont = 1'b1; w.jmp = JMP_NEXT; end
            STEP_G2:       begin w.emit = 1'b1; w.src = SRC_G2; w.cont = 1'b1; w.jmp = JMP_NEXT; end
            STEP_G1:       begin w.emit = 1'b1; w.src = SRC_G1; w.cont = 1'b1; w.jmp = JMP_NEXT; end
            STEP_G0:       begin w.emit = 1'b1; w.src = SRC_G0;     w.jmp = JMP_NEXT; end
            STEP_OFF_ST:   begin w.emit = 1'b1; w.src = SRC_STATUS; w.jmp = JMP_NEXT; end
            STEP_OFF_NOTE: begin w.emit = 1'b1; w.src = SRC_NOTE;   w.jmp = JMP_NEXT; end
            STEP_OFF_VEL:  begin w.emit = 1'b1; w.src = SRC_ZERO; w.last = 1'b1;
                                 w.jmp = JMP_HOME; end
            default:       begin w.jmp = JMP_HOME; end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/midi_note_event_serializer_core.sv
// Top level of the MIDI note event serializer: microcoded byte sequencer.
//
// Usage:
//   Slave stream (s_axis_*) takes one note word per handshake: duration,
//   note number and velocity. Master stream (m_axis_*) gives the standard
//   MIDI file event pair for that note, one byte per word: zero delta,
//   Note On status/note/velocity, the scaled duration as a 1 to 4 byte
//   big-endian variable-length quantity, then Note On status/note/0.
//   tlast marks the final byte of each note.
//   Configuration (cfg_we/cfg_index/cfg_data) sets tick_scale (Q12.16) and
//   the MIDI channel; write it only while no note is in flight.
// Sequence:
//   A note is N = 8..11 bytes: one step to accept the word, one for the
//   16x28 duration multiply, then one microcode step per byte through the
//   single output register.
//   The first byte is loaded into the output register at the zero-delta step, which follows the multiply step.
// Reset:
//   rst_n clears the step counter and output valid; tick_scale returns to
//   1.0 and the channel to 0.
// Stall:
//   When m_axis_tready is low the byte holds in the output register and the
//   sequencer stops at the next emitting step until the slot drains.
module midi_note_event_serializer_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [27:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] duration, [22:16] note_number,
                                        // [29:23] velocity, [31:30] zero
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last
);

    localparam int unsigned PC_W    = mnes_pkg::PC_W;
    localparam int unsigned TICKS_W = mnes_pkg::TICKS_W;
    localparam int unsigned PROD_W  = mnes_pkg::DUR_W + mnes_pkg::SCALE_W;

    // configuration registers
    logic [mnes_pkg::SCALE_W-1:0] tick_scale_reg;
    logic [mnes_pkg::CHAN_W-1:0]  midi_channel_reg;

    // sequencer and datapath
    logic [PC_W-1:0]              pc_reg, pc_next;
    logic [mnes_pkg::DUR_W-1:0]   dur_reg;
    logic [mnes_pkg::NOTE_W-1:0]  note_reg;
    logic [mnes_pkg::NOTE_W-1:0]  vel_reg;
    logic [TICKS_W-1:0]           ticks_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_byte_reg;
    logic                         out_last_reg;

    mnes_pkg::ctrl_word_t         cw;
    logic                         slot_free;
    logic                         in_accept;
    logic                         advance;
    logic                         do_emit;
    logic [PROD_W-1:0]            prod;
    logic [7:0]                   status;
    logic [7:0]                   byte_sel;
    logic [PC_W-1:0]              vlq_target;

    assign cw        = mnes_pkg::ucode(pc_reg);
    assign slot_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = cw.wait_in;
    assign in_accept     = s_axis_tvalid && cw.wait_in;

    assign do_emit = cw.emit && slot_free;

    // Stall at the input step until a word arrives, at an emit step until the slot drains.
    always_comb
    begin
        priority if (cw.wait_in)
            advance = s_axis_tvalid;
        else if (cw.emit)
            advance = slot_free;
        else
            advance = 1'b1;
    end

    // Full product >> 16 fits 28 bits, so it never exceeds 0x0FFFFFFF and
    // the saturation limit is met by construction.
    assign prod = {{mnes_pkg::SCALE_W{1'b0}}, dur_reg}
                * {{mnes_pkg::DUR_W{1'b0}}, tick_scale_reg};

    assign status = mnes_pkg::NOTE_ON_STATUS | {4'h0, midi_channel_reg};

    // Skip the leading zero groups of the quantity.
    always_comb
    begin
        priority if (ticks_reg[27:21] != 7'd0)
            vlq_target = mnes_pkg::STEP_G3;
        else if (ticks_reg[20:14] != 7'd0)
            vlq_target = mnes_pkg::STEP_G2;
        else if (ticks_reg[13:7] != 7'd0)
            vlq_target = mnes_pkg::STEP_G1;
        else
            vlq_target = mnes_pkg::STEP_G0;
    end

    always_comb
    begin
        unique case (cw.src)
            mnes_pkg::SRC_ZERO:   byte_sel = 8'h00;
            mnes_pkg::SRC_STATUS: byte_sel = status;
            mnes_pkg::SRC_NOTE:   byte_sel = {1'b0, note_reg};
            mnes_pkg::SRC_VEL:    byte_sel = {1'b0, vel_reg};
            mnes_pkg::SRC_G3:     byte_sel = {cw.cont, ticks_reg[27:21]};
            mnes_pkg::SRC_G2:     byte_sel = {cw.cont, ticks_reg[20:14]};
            mnes_pkg::SRC_G1:     byte_sel = {cw.cont, ticks_reg[13:7]};
            mnes_pkg::SRC_G0:     byte_sel = {cw.cont, ticks_reg[6:0]};
            default:              byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (advance)
        begin
            unique case (cw.jmp)
                mnes_pkg::JMP_NEXT: pc_next = pc_reg + 4'd1;
                mnes_pkg::JMP_VLQ:  pc_next = vlq_target;
                mnes_pkg::JMP_HOME: pc_next = mnes_pkg::STEP_IDLE;
                default:            pc_next = mnes_pkg::STEP_IDLE;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (do_emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= mnes_pkg::STEP_IDLE;
            out_valid_reg    <= 1'b0;
            tick_scale_reg   <= mnes_pkg::TICK_SCALE_RESET;
            midi_channel_reg <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mnes_pkg::CFG_TICK_SCALE:   tick_scale_reg   <= cfg_data;
                    mnes_pkg::CFG_MIDI_CHANNEL: midi_channel_reg <= cfg_data[3:0];
                    default:                    tick_scale_reg   <= tick_scale_reg;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dur_reg  <= s_axis_tdata[15:0];
            note_reg <= s_axis_tdata[22:16];
            vel_reg  <= s_axis_tdata[29:23];
        end
        if (cw.load_mul)
            ticks_reg <= prod[PROD_W-1:mnes_pkg::FRAC_W];
        if (do_emit)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= cw.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    // An accepted note always goes to the multiply step next.
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> pc_reg == mnes_pkg::STEP_MUL)
        else $error("accepted note did not start the multiply step");

    // The scaled duration holds while its bytes are being emitted.
    a_ticks_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg > mnes_pkg::STEP_MUL) |=> $stable(ticks_reg))
        else $error("ticks changed during byte emission");

    // The final quantity byte never carries the continuation bit.
    a_vlq_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == mnes_pkg::STEP_G0 && do_emit) |=> !m_axis_tdata[7])
        else $error("final quantity byte has continuation bit set");

    // A continuation byte is always followed by another quantity step.
    a_vlq_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (do_emit && cw.cont) |=> (pc_reg == mnes_pkg::STEP_G2
                                  || pc_reg == mnes_pkg::STEP_G1
                                  || pc_reg == mnes_pkg::STEP_G0))
        else $error("continuation byte not followed by quantity byte");

    // The last byte of a note returns the program home.
    a_last_home: assert property (@(posedge clk) disable iff (!rst_n)
        (do_emit && cw.last) |=> pc_reg == mnes_pkg::STEP_IDLE)
        else $error("sequencer did not return home after last byte");

endmodule

FILE: tb/sv/midi_note_event_serializer_core_test.sv
// Self-checking testbench for the MIDI note event serializer core.
`timescale 1ns / 1ps

module midi_note_event_serializer_core_test;

    // One note word as it sits in s_axis_tdata, lowest field first from the bottom.
    typedef struct packed {
        logic [6:0]  vel;
        logic [6:0]  num;
        logic [15:0] dur;
    } note_word_t;

    // One expected output word: the event byte and its end-of-note flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } midi_byte_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_FREE,     // always ready
        RX_COIN,     // ready half of the time
        RX_MOSTLY,   // ready with probability seven in eight
        RX_TRICKLE   // ready with probability one in eight
    } rx_mode_t;

    localparam logic [27:0] TICKS_MAX    = 28'h0FFFFFF;
    localparam logic [27:0] TICKS_LIMIT  = 28'hFFFFFFF;
    localparam logic [27:0] SCALE_MAX    = 28'hFFFFFFF;
    localparam int          HOLD_AT_NOTE = 150;  // note count that triggers the long hold-off
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RAND_PHASES  = 4;
    localparam int          RAND_NOTES   = 100;  // per random phase

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [27:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [15:0] duration, [22:16] note_number,
                                      // [29:23] velocity, [31:30] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] out_byte
    logic        m_axis_tlast;        // last

    midi_note_event_serializer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Mirror of the configuration registers, kept by the register write task.
    logic [27:0] scale_reg = mnes_pkg::TICK_SCALE_RESET;
    logic [3:0]  chan_reg  = '0;

    note_word_t note_q[$];       // notes waiting for the driver
    midi_byte_t midi_bytes_q[$]; // event bytes still owed by the block
    int         notes_in   = 0;  // notes accepted so far
    int         mismatches = 0;
    logic       note_taken = 1'b0;  // input word accepted at the last rising edge

    initial begin
        forever #5 clk = ~clk;
    end

    // Hard limit on the run; far beyond the slowest legal schedule.
    initial begin
        #5_000_000;
        $display("midi_note_event_serializer_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction: scale the duration, split it into 7-bit groups and lay
    // out the full Note On / Note On velocity 0 pair, one byte per word.
    // ------------------------------------------------------------------
    function automatic void predict_note_events(input logic [15:0] dur,
                                                input logic [6:0] num,
                                                input logic [6:0] vel);
        logic [43:0] prod;
        logic [27:0] ticks;
        logic [7:0]  status;
        int          ngroups;
        prod = dur * scale_reg;
        // The product never exceeds 28 integer bits, but keep the clamp anyway.
        if ((prod >> mnes_pkg::FRAC_W) > {16'd0, TICKS_LIMIT})
            ticks = TICKS_LIMIT;
        else
            ticks = prod[43:16];
        if (ticks[27:21] != 0)
            ngroups = 4;
        else if (ticks[20:14] != 0)
            ngroups = 3;
        else if (ticks[13:7] != 0)
            ngroups = 2;
        else
            ngroups = 1;
        status = mnes_pkg::NOTE_ON_STATUS | {4'd0, chan_reg};
        midi_bytes_q.push_back('{data: 8'h00, last: 1'b0});
        midi_bytes_q.push_back('{data: status, last: 1'b0});
        midi_bytes_q.push_back('{data: {1'b0, num}, last: 1'b0});
        midi_bytes_q.push_back('{data: {1'b0, vel}, last: 1'b0});
        // Big-endian quantity: continuation bit on all but the final group.
        for (int i = ngroups - 1; i >= 0; i--)
            midi_bytes_q.push_back('{data: {(i > 0), ticks[7*i +: 7]}, last: 1'b0});
        midi_bytes_q.push_back('{data: status, last: 1'b0});
        midi_bytes_q.push_back('{data: {1'b0, num}, last: 1'b0});
        midi_bytes_q.push_back('{data: 8'h00, last: 1'b1});
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge, predict on every
    // accepted note and compare every accepted byte with the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        midi_byte_t want;
        note_word_t w;
        note_taken = 1'b0;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (midi_bytes_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected byte %02h last %0b with nothing owed",
                                 m_axis_tdata, m_axis_tlast);
                end
                else begin
                    want = midi_bytes_q.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                     want.data, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                w = s_axis_tdata[29:0];
                predict_note_events(w.dur, w.num, w.vel);
                note_taken = 1'b1;
                notes_in++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer notes in bursts of random length with random gaps; hold
    // each word until it is taken. Compute the next value first so that each
    // signal gets one assignment per step.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk) begin
        logic        nxt_valid;
        logic [31:0] nxt_data;
        note_word_t  w;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end
        else begin
            if (s_axis_tvalid && note_taken)
                nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (note_q.size() != 0) begin
                    w         = note_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data  = {2'b00, w};
                    if (burst_left > 1) begin
                        burst_left--;
                    end
                    else begin
                        // New burst; about a third of the time no gap at all.
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    // ------------------------------------------------------------------
    // Receiver: switch between stall patterns at random, and once hold off
    // for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------
    rx_mode_t rx_mode   = RX_FREE;
    int       mode_left = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;

    always @(negedge clk) begin
        logic rdy;
        rdy = 1'b0;
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
            end
            else if (!hold_done && notes_in >= HOLD_AT_NOTE) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_FREE:    rdy = 1'b1;
                    RX_COIN:    rdy = ($urandom_range(0, 1) != 0);
                    RX_MOSTLY:  rdy = ($urandom_range(0, 7) != 0);
                    RX_TRICKLE: rdy = ($urandom_range(0, 7) == 0);
                    default:    rdy = 1'b1;
                endcase
            end
        end
        m_axis_tready <= rdy;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic idx, input logic [27:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == mnes_pkg::CFG_TICK_SCALE)
            scale_reg = val;
        else
            chan_reg = val[3:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_note(input logic [15:0] dur, input logic [6:0] num,
                              input logic [6:0] vel);
        note_q.push_back('{vel: vel, num: num, dur: dur});
    endtask

    // Hold until the driver is empty and every owed byte has arrived.
    task automatic wait_drained();
        while (note_q.size() != 0 || s_axis_tvalid || midi_bytes_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        logic [15:0] dur;
        logic [27:0] scale;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings (scale 1.0, channel 0): quantities of 1, 2 and 3
        // bytes, zero duration, and the extremes of note and velocity.
        queue_note(16'd0,     7'd0,   7'd0);
        queue_note(16'd127,   7'd127, 7'd127);
        queue_note(16'd128,   7'd60,  7'd100);
        queue_note(16'd16383, 7'd1,   7'd64);
        queue_note(16'd16384, 7'd127, 7'd1);
        queue_note(16'd65535, 7'd0,   7'd127);
        wait_drained();

        // Largest scale and channel 15 (upper data bits set): quantities of one
        // to four bytes, and the largest tick count.
        write_reg(mnes_pkg::CFG_TICK_SCALE, SCALE_MAX);
        write_reg(mnes_pkg::CFG_MIDI_CHANNEL, 28'hFFFFFFF);
        queue_note(16'd65535, 7'd127, 7'd127);
        queue_note(16'd2048,  7'd42,  7'd85);
        queue_note(16'd33,    7'd85,  7'd42);
        queue_note(16'd1,     7'd0,   7'd127);
        queue_note(16'd0,     7'd127, 7'd0);
        wait_drained();

        // Zero scale: every duration collapses to a single zero byte.
        write_reg(mnes_pkg::CFG_TICK_SCALE, 28'd0);
        write_reg(mnes_pkg::CFG_MIDI_CHANNEL, 28'd9);
        queue_note(16'd65535, 7'd64, 7'd64);
        queue_note(16'd1,     7'd12, 7'd99);
        wait_drained();

        // Half scale: truncation of the fraction.
        write_reg(mnes_pkg::CFG_TICK_SCALE, 28'h0008000);
        write_reg(mnes_pkg::CFG_MIDI_CHANNEL, 28'd0);
        queue_note(16'd1,     7'd33,  7'd77);
        queue_note(16'd3,     7'd34,  7'd78);
        queue_note(16'd255,   7'd35,  7'd79);
        queue_note(16'd65535, 7'd36,  7'd80);
        wait_drained();

        // Random phases, each with its own settings.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       scale = 28'($urandom);
                1:       scale = 28'($urandom_range(32768, 262144));
                2:       scale = 28'($urandom_range(0, 4095));
                default: scale = ($urandom_range(0, 1) != 0) ? SCALE_MAX : TICKS_MAX;
            endcase
            write_reg(mnes_pkg::CFG_TICK_SCALE, scale);
            write_reg(mnes_pkg::CFG_MIDI_CHANNEL, 28'($urandom));
            for (int k = 0; k < RAND_NOTES; k++) begin
                case ($urandom_range(0, 3))
                    0, 1:    dur = 16'($urandom_range(0, 65535));
                    2:       dur = 16'($urandom_range(0, 255));
                    default: dur = 16'((32'd1 << $urandom_range(0, 15))
                                       - $urandom_range(0, 1));
                endcase
                queue_note(dur, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            end
            wait_drained();
        end

        // Let any stray byte show up before the verdict.
        repeat (20) @(posedge clk);
        if (mismatches == 0 && midi_bytes_q.size() == 0)
            $display("midi_note_event_serializer_core test passed");
        else
            $display("midi_note_event_serializer_core test failed");
        $finish;
    end

endmodule
